### hdl/ale_pkg.sv
// Shared types and codes of the array list engine.
package ale_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 3;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [OP_W-1:0] {
    OP_HEAD      = 3'd0,
    OP_TAIL      = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_DELETE_AT = 3'd3,
    OP_FIND      = 3'd4,
    OP_READ      = 3'd5,
    OP_CLEAR     = 3'd6
  } ale_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } ale_status_e;

endpackage

### hdl/ale_req_if.sv
// Request channel of the array list engine.
interface ale_req_if import ale_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  value_t            value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

### hdl/ale_rsp_if.sv
// Response channel of the array list engine.
interface ale_rsp_if import ale_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [POS_W-1:0]  found_position;
  value_t            read_value;
  logic [POS_W-1:0]  element_count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output status, output found_position, output read_value,
                  output element_count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input found_position, input read_value,
                  input element_count, input is_empty, input is_full, output ready);
endinterface

### hdl/array_list_engine_unit.sv
// Array list engine: ordered list of signed words held in one synchronous memory.
// Inserts and deletes move the elements behind the position one place up or down; find scans
// from the head until a match or the end of the list; read fetches one word; clear and errors
// answer without moving any element.
// The engine is ready for the next request in the cycle after the response is loaded; the
// element walk goes through the single memory port, one word per cycle. Reset empties the list.
module array_list_engine_unit import ale_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ale_req_if.sink   req_i,
  ale_rsp_if.source rsp_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_DN     = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_RD     = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    ptr_q, ptr_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic [POS_W-1:0] found_q, found_d;
  value_t           rd_q, rd_d;
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  value_t           val_q;

  value_t           mem [CAPACITY];
  value_t           rdata_q;
  logic             we;
  logic [IW-1:0]    wa;
  value_t           wd;
  logic [IW-1:0]    ra;

  logic [PW-1:0]    pos_ext, cnt_ext, pos_m1, found_ext;
  logic             list_full, list_empty, ins_bad, acc_bad;
  logic [IW-1:0]    ins_idx;
  logic             req_xfer, rsp_free, rsp_load;

  logic             rsp_valid_q;
  logic [ST_W-1:0]  rsp_status_q;
  logic [POS_W-1:0] rsp_found_q;
  value_t           rsp_read_q;
  logic [POS_W-1:0] rsp_count_q;
  logic             rsp_empty_q, rsp_full_q;

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign rsp_load    = (state_q == S_FIN) && rsp_free;

  // Position checks against the current count
  assign pos_ext    = {{(PW-POS_W){1'b0}}, pos_q};
  assign cnt_ext    = {{(PW-CW){1'b0}}, cnt_q};
  assign pos_m1     = pos_ext - PW'(1);
  assign found_ext  = {{(PW-IW){1'b0}}, ptr_q} + PW'(1);
  assign list_full  = (cnt_q == CW'(CAPACITY));
  assign list_empty = (cnt_q == '0);
  assign ins_bad    = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
  assign acc_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);

  // Gap index for the three insert kinds
  always_comb begin
    unique case (op_q)
      OP_HEAD:      ins_idx = '0;
      OP_TAIL:      ins_idx = cnt_ext[IW-1:0];
      default:      ins_idx = pos_m1[IW-1:0];
    endcase
  end

  // Hold the request while it is worked on
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q  <= req_i.operation;
      pos_q <= req_i.position;
      val_q <= req_i.value;
    end
  end

  // Element memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  // Sequencer: walk the memory one word per cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    st_d    = st_q;
    found_d = found_q;
    rd_d    = rd_q;
    we      = 1'b0;
    wa      = ptr_q + IW'(1);
    wd      = rdata_q;
    ra      = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) state_d = S_DECODE;
      end
      S_DECODE: begin
        st_d    = ST_OK;
        found_d = '0;
        rd_d    = '0;
        state_d = S_FIN;
        unique case (op_q)
          OP_HEAD, OP_TAIL, OP_INSERT_AT: begin
            if (list_full) begin
              st_d = ST_FULL;
            end else if (op_q == OP_INSERT_AT && ins_bad) begin
              st_d = ST_BAD_POS;
            end else if (cnt_ext > {{(PW-IW){1'b0}}, ins_idx}) begin
              // open the gap from the tail downwards
              ra      = IW'(cnt_q - CW'(1));
              ptr_d   = IW'(cnt_q - CW'(1));
              state_d = S_UP;
            end else begin
              we    = 1'b1;
              wa    = ins_idx;
              wd    = val_q;
              cnt_d = cnt_q + CW'(1);
            end
          end
          OP_DELETE_AT: begin
            if (list_empty) begin
              st_d = ST_EMPTY;
            end else if (acc_bad) begin
              st_d = ST_BAD_POS;
            end else if (pos_ext < cnt_ext) begin
              ra      = pos_ext[IW-1:0];
              ptr_d   = pos_ext[IW-1:0];
              state_d = S_DN;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          OP_FIND: begin
            if (list_empty) begin
              st_d = ST_EMPTY;
            end else begin
              ra      = '0;
              ptr_d   = '0;
              state_d = S_SCAN;
            end
          end
          OP_READ: begin
            if (list_empty) begin
              st_d = ST_EMPTY;
            end else if (acc_bad) begin
              st_d = ST_BAD_POS;
            end else begin
              ra      = pos_m1[IW-1:0];
              state_d = S_RD;
            end
          end
          OP_CLEAR: begin
            cnt_d = '0;
          end
          default: ;
        endcase
      end
      S_UP: begin
        // move the word read last cycle one place up
        we = 1'b1;
        wa = ptr_q + IW'(1);
        wd = rdata_q;
        if (ptr_q == ins_idx) begin
          state_d = S_PUT;
        end else begin
          ra    = ptr_q - IW'(1);
          ptr_d = ptr_q - IW'(1);
        end
      end
      S_PUT: begin
        we      = 1'b1;
        wa      = ins_idx;
        wd      = val_q;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_FIN;
      end
      S_DN: begin
        // move the word read last cycle one place down
        we = 1'b1;
        wa = ptr_q - IW'(1);
        wd = rdata_q;
        if ((CW'(ptr_q) + CW'(1)) == cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FIN;
        end else begin
          ra    = ptr_q + IW'(1);
          ptr_d = ptr_q + IW'(1);
        end
      end
      S_SCAN: begin
        if (rdata_q == val_q) begin
          found_d = found_ext[POS_W-1:0];
          state_d = S_FIN;
        end else if ((CW'(ptr_q) + CW'(1)) == cnt_q) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_FIN;
        end else begin
          ra    = ptr_q + IW'(1);
          ptr_d = ptr_q + IW'(1);
        end
      end
      S_RD: begin
        rd_d    = rdata_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (rsp_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    st_q    <= st_d;
    found_q <= found_d;
    rd_q    <= rd_d;
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= st_q;
      rsp_found_q  <= found_q;
      rsp_read_q   <= rd_q;
      rsp_count_q  <= cnt_ext[POS_W-1:0];
      rsp_empty_q  <= list_empty;
      rsp_full_q   <= list_full;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.read_value     = rsp_read_q;
  assign rsp_o.element_count  = rsp_count_q;
  assign rsp_o.is_empty       = rsp_empty_q;
  assign rsp_o.is_full        = rsp_full_q;

endmodule
